>>> sv/s5hp_pkg.sv
`timescale 1ns / 1ps
// s5hp_pkg: shared codes, constants and the result burst descriptor
// for the SOCKS5 handshake parser. No dependencies.
package s5hp_pkg;

  // parser phases
  localparam logic [2:0] PH_GREET   = 3'd0;
  localparam logic [2:0] PH_METHODS = 3'd1;
  localparam logic [2:0] PH_HEADER  = 3'd2;
  localparam logic [2:0] PH_ALEN    = 3'd3;
  localparam logic [2:0] PH_ABODY   = 3'd4;
  localparam logic [2:0] PH_PORT    = 3'd5;
  localparam logic [2:0] PH_DONE    = 3'd6;
  localparam logic [2:0] PH_ERROR   = 3'd7;

  // result kinds
  localparam logic [1:0] K_REPLY = 2'd0;
  localparam logic [1:0] K_ADDR  = 2'd1;
  localparam logic [1:0] K_DONE  = 2'd2;
  localparam logic [1:0] K_ERR   = 2'd3;

  // address kinds
  localparam logic [1:0] AK_IPV4   = 2'd0;
  localparam logic [1:0] AK_DOMAIN = 2'd1;
  localparam logic [1:0] AK_IPV6   = 2'd2;

  // error codes
  localparam logic [2:0] E_GREET_VER = 3'd0;
  localparam logic [2:0] E_NO_METH   = 3'd1;
  localparam logic [2:0] E_NO_ACCEPT = 3'd2;
  localparam logic [2:0] E_REQ_VER   = 3'd3;
  localparam logic [2:0] E_BAD_CMD   = 3'd4;
  localparam logic [2:0] E_BAD_ATYP  = 3'd5;
  localparam logic [2:0] E_EMPTY_DOM = 3'd6;
  localparam logic [2:0] E_AFTER_ERR = 3'd7;

  // protocol bytes
  localparam logic [7:0] B_VER5      = 8'h05;
  localparam logic [7:0] B_ZERO      = 8'h00;
  localparam logic [7:0] B_NO_AUTH   = 8'h00;
  localparam logic [7:0] B_NO_METH   = 8'hFF;
  localparam logic [7:0] B_CONNECT   = 8'h01;
  localparam logic [7:0] B_ATYP_IPV4 = 8'h01;
  localparam logic [7:0] B_ATYP_DOM  = 8'h03;
  localparam logic [7:0] B_ATYP_IPV6 = 8'h04;
  localparam logic [7:0] B_REP_CMD   = 8'h07;
  localparam logic [7:0] B_REP_ATYP  = 8'h08;

  localparam logic [7:0] LEN_IPV4 = 8'd4;
  localparam logic [7:0] LEN_IPV6 = 8'd16;

  // burst types
  localparam logic [1:0] BT_REPLY = 2'd0;
  localparam logic [1:0] BT_ADDR  = 2'd1;
  localparam logic [1:0] BT_DONE  = 2'd2;

  // reply burst slots
  localparam logic [3:0] SLOT_VER  = 4'd0;
  localparam logic [3:0] SLOT_CODE = 4'd1;
  localparam logic [3:0] SLOT_ATYP = 4'd3;
  localparam logic [3:0] REJ_LAST  = 4'd10;

  typedef struct packed {
    logic [1:0]  btype;
    logic [7:0]  dat;
    logic [1:0]  ak;
    logic [15:0] port;
    logic [2:0]  err;
    logic        has_err;
    logic [3:0]  len;   // index of last result in burst
  } desc_t;

endpackage

>>> sv/s5hp_parser.sv
`timescale 1ns / 1ps
// s5hp_parser: handshake state and per-item decode into a result burst
// descriptor. Depends on s5hp_pkg.
module s5hp_parser (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  logic [7:0]    byte_in,
  output s5hp_pkg::desc_t desc,
  output logic          has_res
);
  import s5hp_pkg::*;

  logic [2:0]  phase_r, phase_nxt;
  logic [7:0]  method_count_r, method_count_nxt;
  logic [8:0]  method_index_r, method_index_nxt;
  logic        saw_no_auth_r, saw_no_auth_nxt;
  logic [1:0]  header_index_r, header_index_nxt;
  logic [7:0]  hdr_ver_r, hdr_ver_nxt;
  logic [7:0]  hdr_cmd_r, hdr_cmd_nxt;
  logic [1:0]  addr_type_r, addr_type_nxt;
  logic [7:0]  addr_length_r, addr_length_nxt;
  logic [7:0]  addr_index_r, addr_index_nxt;
  logic [15:0] port_value_r, port_value_nxt;
  logic [1:0]  port_index_r, port_index_nxt;

  always_comb begin
    phase_nxt        = phase_r;
    method_count_nxt = method_count_r;
    method_index_nxt = method_index_r;
    saw_no_auth_nxt  = saw_no_auth_r;
    header_index_nxt = header_index_r;
    hdr_ver_nxt      = hdr_ver_r;
    hdr_cmd_nxt      = hdr_cmd_r;
    addr_type_nxt    = addr_type_r;
    addr_length_nxt  = addr_length_r;
    addr_index_nxt   = addr_index_r;
    port_value_nxt   = port_value_r;
    port_index_nxt   = port_index_r;
    desc             = '0;
    has_res          = 1'b0;

    case (phase_r)
      PH_GREET: begin
        if (byte_in != B_VER5) begin
          has_res      = 1'b1;
          desc.has_err = 1'b1;
          desc.err     = E_GREET_VER;
          phase_nxt    = PH_ERROR;
        end else begin
          phase_nxt        = PH_METHODS;
          method_index_nxt = 9'd0;
          saw_no_auth_nxt  = 1'b0;
        end
      end
      PH_METHODS: begin
        if (method_index_r == 9'd0) begin
          method_count_nxt = byte_in;
          if (byte_in == B_ZERO) begin
            has_res      = 1'b1;
            desc.has_err = 1'b1;
            desc.err     = E_NO_METH;
            phase_nxt    = PH_ERROR;
          end else begin
            method_index_nxt = 9'd1;
          end
        end else begin
          saw_no_auth_nxt  = saw_no_auth_r | (byte_in == B_NO_AUTH);
          method_index_nxt = method_index_r + 9'd1;
          if (method_index_nxt > {1'b0, method_count_r}) begin
            has_res = 1'b1;
            if (saw_no_auth_nxt) begin
              desc.dat         = B_NO_AUTH;
              desc.len         = 4'd1;
              phase_nxt        = PH_HEADER;
              header_index_nxt = 2'd0;
            end else begin
              desc.dat     = B_NO_METH;
              desc.len     = 4'd2;
              desc.has_err = 1'b1;
              desc.err     = E_NO_ACCEPT;
              phase_nxt    = PH_ERROR;
            end
          end
        end
      end
      PH_HEADER: begin
        if (header_index_r != 2'd3) begin
          if (header_index_r == 2'd0) hdr_ver_nxt = byte_in;
          if (header_index_r == 2'd1) hdr_cmd_nxt = byte_in;
          header_index_nxt = header_index_r + 2'd1;
        end else begin
          header_index_nxt = 2'd0;
          if (hdr_ver_r != B_VER5) begin
            has_res      = 1'b1;
            desc.has_err = 1'b1;
            desc.err     = E_REQ_VER;
            phase_nxt    = PH_ERROR;
          end else if (hdr_cmd_r != B_CONNECT) begin
            has_res      = 1'b1;
            desc.dat     = B_REP_CMD;
            desc.len     = REJ_LAST;
            desc.has_err = 1'b1;
            desc.err     = E_BAD_CMD;
            phase_nxt    = PH_ERROR;
          end else if (byte_in == B_ATYP_IPV4) begin
            addr_type_nxt   = AK_IPV4;
            addr_length_nxt = LEN_IPV4;
            addr_index_nxt  = 8'd0;
            phase_nxt       = PH_ABODY;
          end else if (byte_in == B_ATYP_DOM) begin
            addr_type_nxt = AK_DOMAIN;
            phase_nxt     = PH_ALEN;
          end else if (byte_in == B_ATYP_IPV6) begin
            addr_type_nxt   = AK_IPV6;
            addr_length_nxt = LEN_IPV6;
            addr_index_nxt  = 8'd0;
            phase_nxt       = PH_ABODY;
          end else begin
            has_res      = 1'b1;
            desc.dat     = B_REP_ATYP;
            desc.len     = REJ_LAST;
            desc.has_err = 1'b1;
            desc.err     = E_BAD_ATYP;
            phase_nxt    = PH_ERROR;
          end
        end
      end
      PH_ALEN: begin
        addr_length_nxt = byte_in;
        if (byte_in == B_ZERO) begin
          has_res      = 1'b1;
          desc.has_err = 1'b1;
          desc.err     = E_EMPTY_DOM;
          phase_nxt    = PH_ERROR;
        end else begin
          addr_index_nxt = 8'd0;
          phase_nxt      = PH_ABODY;
        end
      end
      PH_ABODY: begin
        has_res        = 1'b1;
        desc.btype     = BT_ADDR;
        desc.dat       = byte_in;
        desc.ak        = addr_type_r;
        addr_index_nxt = addr_index_r + 8'd1;
        if (addr_index_nxt == addr_length_r) begin
          port_value_nxt = 16'd0;
          port_index_nxt = 2'd0;
          phase_nxt      = PH_PORT;
        end
      end
      PH_PORT: begin
        port_value_nxt = {port_value_r[7:0], byte_in};
        port_index_nxt = port_index_r + 2'd1;
        if (port_index_nxt == 2'd2) begin
          has_res    = 1'b1;
          desc.btype = BT_DONE;
          desc.ak    = addr_type_r;
          desc.port  = port_value_nxt;
          phase_nxt  = PH_DONE;
        end
      end
      PH_DONE: begin
      end
      default: begin
        has_res      = 1'b1;
        desc.has_err = 1'b1;
        desc.err     = E_AFTER_ERR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_GREET;
      method_count_r <= 8'd0;
      method_index_r <= 9'd0;
      saw_no_auth_r  <= 1'b0;
      header_index_r <= 2'd0;
      addr_type_r    <= AK_IPV4;
      addr_length_r  <= 8'd0;
      addr_index_r   <= 8'd0;
      port_value_r   <= 16'd0;
      port_index_r   <= 2'd0;
    end else if (step) begin
      phase_r        <= phase_nxt;
      method_count_r <= method_count_nxt;
      method_index_r <= method_index_nxt;
      saw_no_auth_r  <= saw_no_auth_nxt;
      header_index_r <= header_index_nxt;
      addr_type_r    <= addr_type_nxt;
      addr_length_r  <= addr_length_nxt;
      addr_index_r   <= addr_index_nxt;
      port_value_r   <= port_value_nxt;
      port_index_r   <= port_index_nxt;
    end
  end

  // header bytes are always written before they are read
  always_ff @(posedge clk) begin
    if (step) begin
      hdr_ver_r <= hdr_ver_nxt;
      hdr_cmd_r <= hdr_cmd_nxt;
    end
  end

endmodule

>>> sv/s5hp_emitter.sv
`timescale 1ns / 1ps
// s5hp_emitter: holds one result burst descriptor and plays it out,
// one result per cycle while out_stall is low. Depends on s5hp_pkg.
module s5hp_emitter (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load,
  input  s5hp_pkg::desc_t desc_in,
  output logic            free,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [1:0]      out_kind,
  output logic [7:0]      out_data,
  output logic [1:0]      out_addr_kind,
  output logic [15:0]     out_dest_port,
  output logic [2:0]      out_error_code,
  output logic            out_last
);
  import s5hp_pkg::*;

  desc_t      desc_r;
  logic       vld_r;
  logic [3:0] cnt_r;
  logic       err_slot;

  assign out_valid = vld_r;
  assign out_last  = (cnt_r == desc_r.len);
  assign free      = !vld_r || (out_last && !out_stall);
  assign err_slot  = desc_r.has_err && out_last;

  always_comb begin
    out_kind       = K_REPLY;
    out_data       = B_ZERO;
    out_addr_kind  = AK_IPV4;
    out_dest_port  = 16'd0;
    out_error_code = E_GREET_VER;
    case (desc_r.btype)
      BT_ADDR: begin
        out_kind      = K_ADDR;
        out_data      = desc_r.dat;
        out_addr_kind = desc_r.ak;
      end
      BT_DONE: begin
        out_kind      = K_DONE;
        out_addr_kind = desc_r.ak;
        out_dest_port = desc_r.port;
      end
      default: begin
        if (err_slot) begin
          out_kind       = K_ERR;
          out_error_code = desc_r.err;
        end else if (cnt_r == SLOT_VER) begin
          out_data = B_VER5;
        end else if (cnt_r == SLOT_CODE) begin
          out_data = desc_r.dat;
        end else if (cnt_r == SLOT_ATYP) begin
          out_data = B_ATYP_IPV4;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      cnt_r <= 4'd0;
    end else if (load) begin
      vld_r <= 1'b1;
      cnt_r <= 4'd0;
    end else if (vld_r && !out_stall) begin
      if (out_last) begin
        vld_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      desc_r <= desc_in;
    end
  end

endmodule

>>> sv/socks5_handshake_parser.sv
`timescale 1ns / 1ps
// socks5_handshake_parser: top level, input register, parser and emitter.
// Depends on s5hp_pkg, s5hp_parser, s5hp_emitter.
//
//   channel | ports                                   | dir
//   in      | in_valid, in_stall, in_byte_in          | client byte in
//   out     | out_valid, out_stall, out_kind, out_data,| result out
//           | out_addr_kind, out_dest_port,           |
//           | out_error_code, out_last                |
//
// An item is decoded in the cycle after it is accepted; its first result is
// registered in the emitter before it shows. Items with one or no result
// sustain one per cycle while out_stall is low. An item with n results holds
// the emitter until all n are out (up to 11, for a reject), and the next
// item with results waits on it. Synchronous active-low reset returns to
// the greeting phase. out_stall freezes the emitter and items with results.
module socks5_handshake_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_data,
  output logic [1:0]  out_addr_kind,
  output logic [15:0] out_dest_port,
  output logic [2:0]  out_error_code,
  output logic        out_last
);
  import s5hp_pkg::*;

  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       advance;
  logic       has_res;
  logic       free;
  desc_t      desc;

  assign advance  = in_vld_r && (!has_res || free);
  assign in_stall = in_vld_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_byte_r <= in_byte_in;
    end
  end

  s5hp_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .byte_in (in_byte_r),
    .desc    (desc),
    .has_res (has_res)
  );

  s5hp_emitter u_emitter (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (advance && has_res),
    .desc_in        (desc),
    .free           (free),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_data       (out_data),
    .out_addr_kind  (out_addr_kind),
    .out_dest_port  (out_dest_port),
    .out_error_code (out_error_code),
    .out_last       (out_last)
  );

`ifndef SYNTHESIS
  a_burst_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=> out_valid)
    else $error("result burst broken");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == K_ERR) |-> out_last)
    else $error("error result not last");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == K_DONE) |-> out_last && (out_data == B_ZERO))
    else $error("bad completion result");
`endif

endmodule
